// File: sv/snrg_pkg.sv
// Package for the spectral noise gain rule pipeline: widths, rule codes and stage metadata.
// Depends on nothing; every other file of the block imports it.
package snrg_pkg;

   localparam int PW         = 32;           // power width used from each input
   localparam int SQW        = 2 * PW;       // width of a squared power
   localparam int KW         = 21;           // width of alpha*16 + beta
   localparam int LW         = SQW + KW;     // width of N^2*(alpha*16 + beta)
   localparam int DW         = SQW + 16;     // divider operand width
   localparam int QW         = 30;           // quotient bits, one per divider stage
   localparam int RW         = QW + 2;       // square root working width
   localparam int SQ_STEPS   = QW / 2 + 1;   // square root stages
   localparam int GAIN_W     = 16;
   localparam int FRAC_W     = 15;           // Wiener gain bits taken from the quotient
   localparam int LATENCY    = 5 + QW + SQ_STEPS + 1;
   localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'h8000;
   localparam logic [GAIN_W-1:0] GAIN_ZERO = 16'h0000;

   typedef enum logic [1:0] {
      RULE_WIENER  = 2'd0,
      RULE_GATING  = 2'd1,
      RULE_GENERAL = 2'd2,
      RULE_PASS    = 2'd3
   } rule_type;

   typedef struct packed {
      logic              is_fixed;
      logic [GAIN_W-1:0] fixed_gain;
      logic              use_sqrt;
      logic              frame_end;
   } meta_type;

endpackage

// File: sv/snrg_front.sv
// Front end of the gain pipeline: input register, squares, scaled products and rule decision.
// Depends on snrg_pkg.
module snrg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  snrg_pkg::rule_type    in_rule,
   input  logic [snrg_pkg::PW-1:0] in_s,
   input  logic [snrg_pkg::PW-1:0] in_n,
   input  logic [15:0]           in_alpha,
   input  logic [15:0]           in_beta,
   input  logic                  in_last,
   output logic                  out_valid,
   output snrg_pkg::meta_type    out_meta,
   output logic [snrg_pkg::DW-1:0] out_num,
   output logic [snrg_pkg::DW-1:0] out_den
);
   import snrg_pkg::*;

   // Stage 0: input capture.
   logic          v0_ff;
   rule_type      rule0_ff;
   logic [PW-1:0] s0_ff, n0_ff;
   logic [15:0]   a0_ff, b0_ff;
   logic          last0_ff;

   // Stage 1: squares.
   logic           v1_ff;
   rule_type       rule1_ff;
   logic [PW-1:0]  s1_ff, n1_ff;
   logic [15:0]    a1_ff, b1_ff;
   logic           last1_ff;
   logic [SQW-1:0] ssq1_ff, nsq1_ff;
   logic [SQW-1:0] ssq1_in, nsq1_in;

   // Stage 2: partial products of N^2 halves.
   logic           v2_ff;
   rule_type       rule2_ff;
   logic [PW-1:0]  s2_ff, n2_ff;
   logic           last2_ff;
   logic [SQW-1:0] ssq2_ff;
   logic [PW+KW-1:0] pkl_ff, pkh_ff, pkl_in, pkh_in;
   logic [PW+15:0]   pal_ff, pah_ff, pbl_ff, pbh_ff;
   logic [PW+15:0]   pal_in, pah_in, pbl_in, pbh_in;
   logic [KW-1:0]    k_sum;

   // Stage 3: assembled products.
   logic           v3_ff;
   rule_type       rule3_ff;
   logic [PW-1:0]  s3_ff, n3_ff;
   logic           last3_ff;
   logic [SQW-1:0] ssq3_ff;
   logic [LW-1:0]  lhs3_ff, lhs3_in;
   logic [DW-1:0]  na3_ff, nb3_ff, na3_in, nb3_in;

   // Stage 4: decision.
   logic           v4_ff;
   meta_type       meta4_ff, meta4_in;
   logic [DW-1:0]  num4_ff, den4_ff, num4_in, den4_in;
   logic [DW-1:0]  rhs, den_a, num_a;
   logic           gen_lt;

   assign ssq1_in = SQW'(s0_ff) * SQW'(s0_ff);
   assign nsq1_in = SQW'(n0_ff) * SQW'(n0_ff);

   assign k_sum  = (KW'(a1_ff) << 4) + KW'(b1_ff);
   assign pkl_in = (PW+KW)'(nsq1_ff[PW-1:0]) * (PW+KW)'(k_sum);
   assign pkh_in = (PW+KW)'(nsq1_ff[SQW-1:PW]) * (PW+KW)'(k_sum);
   assign pal_in = (PW+16)'(nsq1_ff[PW-1:0]) * (PW+16)'(a1_ff);
   assign pah_in = (PW+16)'(nsq1_ff[SQW-1:PW]) * (PW+16)'(a1_ff);
   assign pbl_in = (PW+16)'(nsq1_ff[PW-1:0]) * (PW+16)'(b1_ff);
   assign pbh_in = (PW+16)'(nsq1_ff[SQW-1:PW]) * (PW+16)'(b1_ff);

   assign lhs3_in = (LW'(pkh_ff) << PW) + LW'(pkl_ff);
   assign na3_in  = (DW'(pah_ff) << PW) + DW'(pal_ff);
   assign nb3_in  = (DW'(pbh_ff) << PW) + DW'(pbl_ff);

   assign rhs    = DW'(ssq3_ff) << 16;
   assign den_a  = DW'(ssq3_ff) << 12;
   assign num_a  = den_a - na3_ff;
   assign gen_lt = lhs3_ff < LW'(rhs);

   always_comb begin
      meta4_in.is_fixed   = 1'b1;
      meta4_in.fixed_gain = GAIN_ONE;
      meta4_in.use_sqrt   = 1'b0;
      meta4_in.frame_end  = last3_ff;
      num4_in             = '0;
      den4_in             = DW'(1);
      unique case (rule3_ff)
         RULE_WIENER: begin
            if (n3_ff == '0) begin
               meta4_in.fixed_gain = GAIN_ONE;
            end else if (s3_ff > n3_ff) begin
               meta4_in.is_fixed = 1'b0;
               num4_in           = DW'(s3_ff - n3_ff);
               den4_in           = DW'(s3_ff);
            end else begin
               meta4_in.fixed_gain = GAIN_ZERO;
            end
         end
         RULE_GATING: begin
            meta4_in.fixed_gain = (n3_ff == '0 || s3_ff >= n3_ff) ? GAIN_ONE : GAIN_ZERO;
         end
         RULE_GENERAL: begin
            if (s3_ff == '0) begin
               meta4_in.fixed_gain = GAIN_ONE;
            end else if (gen_lt) begin
               if (na3_ff != '0) begin
                  meta4_in.is_fixed = 1'b0;
                  meta4_in.use_sqrt = 1'b1;
                  num4_in           = num_a;
                  den4_in           = den_a;
               end
            end else if (nb3_ff < rhs) begin
               meta4_in.is_fixed = 1'b0;
               meta4_in.use_sqrt = 1'b1;
               num4_in           = nb3_ff;
               den4_in           = rhs;
            end
         end
         RULE_PASS: begin
            meta4_in.fixed_gain = GAIN_ONE;
         end
         default: begin
            meta4_in.fixed_gain = GAIN_ONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rule0_ff <= in_rule;
      s0_ff    <= in_s;
      n0_ff    <= in_n;
      a0_ff    <= in_alpha;
      b0_ff    <= in_beta;
      last0_ff <= in_last;

      rule1_ff <= rule0_ff;
      s1_ff    <= s0_ff;
      n1_ff    <= n0_ff;
      a1_ff    <= a0_ff;
      b1_ff    <= b0_ff;
      last1_ff <= last0_ff;
      ssq1_ff  <= ssq1_in;
      nsq1_ff  <= nsq1_in;

      rule2_ff <= rule1_ff;
      s2_ff    <= s1_ff;
      n2_ff    <= n1_ff;
      last2_ff <= last1_ff;
      ssq2_ff  <= ssq1_ff;
      pkl_ff   <= pkl_in;
      pkh_ff   <= pkh_in;
      pal_ff   <= pal_in;
      pah_ff   <= pah_in;
      pbl_ff   <= pbl_in;
      pbh_ff   <= pbh_in;

      rule3_ff <= rule2_ff;
      s3_ff    <= s2_ff;
      n3_ff    <= n2_ff;
      last3_ff <= last2_ff;
      ssq3_ff  <= ssq2_ff;
      lhs3_ff  <= lhs3_in;
      na3_ff   <= na3_in;
      nb3_ff   <= nb3_in;

      meta4_ff <= meta4_in;
      num4_ff  <= num4_in;
      den4_ff  <= den4_in;
   end

   assign out_valid = v4_ff;
   assign out_meta  = meta4_ff;
   assign out_num   = num4_ff;
   assign out_den   = den4_ff;

endmodule

// File: sv/snrg_div.sv
// Pipelined restoring divider: one quotient bit per stage, floor(num * 2^QW / den) for num below den.
// Depends on snrg_pkg.
module snrg_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  snrg_pkg::meta_type     in_meta,
   input  logic [snrg_pkg::DW-1:0] in_num,
   input  logic [snrg_pkg::DW-1:0] in_den,
   output logic                   out_valid,
   output snrg_pkg::meta_type     out_meta,
   output logic [snrg_pkg::QW-1:0] out_quot
);
   import snrg_pkg::*;

   logic [QW-1:0] vld_ff;
   meta_type      meta_ff [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quot_ff [QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QW-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DW-1:0] prev_rem, prev_den;
      logic [QW-1:0] prev_quot;
      meta_type      prev_meta;
      logic [DW:0]   shifted;
      logic          ge;
      logic [DW-1:0] rem_in;

      if (i == 0) begin : g_first
         assign prev_rem  = in_num;
         assign prev_den  = in_den;
         assign prev_quot = '0;
         assign prev_meta = in_meta;
      end else begin : g_next
         assign prev_rem  = rem_ff[i-1];
         assign prev_den  = den_ff[i-1];
         assign prev_quot = quot_ff[i-1];
         assign prev_meta = meta_ff[i-1];
      end

      assign shifted = {prev_rem, 1'b0};
      assign ge      = shifted >= {1'b0, prev_den};
      assign rem_in  = ge ? DW'(shifted - {1'b0, prev_den}) : DW'(shifted);

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         den_ff[i]  <= prev_den;
         quot_ff[i] <= {prev_quot[QW-2:0], ge};
         meta_ff[i] <= prev_meta;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_meta  = meta_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];

endmodule

// File: sv/snrg_sqrt.sv
// Pipelined integer square root, two radicand bits per stage, with the top quotient bits carried along.
// Depends on snrg_pkg.
module snrg_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  snrg_pkg::meta_type       in_meta,
   input  logic [snrg_pkg::QW-1:0]  in_quot,
   output logic                     out_valid,
   output snrg_pkg::meta_type       out_meta,
   output logic [snrg_pkg::GAIN_W-1:0] out_root,
   output logic [snrg_pkg::FRAC_W-1:0] out_frac
);
   import snrg_pkg::*;

   logic [SQ_STEPS-1:0] vld_ff;
   meta_type            meta_ff [SQ_STEPS];
   logic [QW-1:0]       rad_ff  [SQ_STEPS];
   logic [RW-1:0]       res_ff  [SQ_STEPS];
   logic [FRAC_W-1:0]   frac_ff [SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SQ_STEPS-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
      localparam logic [RW-1:0] STEP_BIT = RW'(1) << (QW - 2 * i);
      logic [QW-1:0]     prev_rad;
      logic [RW-1:0]     prev_res, trial;
      logic [FRAC_W-1:0] prev_frac;
      meta_type          prev_meta;
      logic              take;

      if (i == 0) begin : g_first
         assign prev_rad  = in_quot;
         assign prev_res  = '0;
         assign prev_frac = in_quot[QW-1:QW-FRAC_W];
         assign prev_meta = in_meta;
      end else begin : g_next
         assign prev_rad  = rad_ff[i-1];
         assign prev_res  = res_ff[i-1];
         assign prev_frac = frac_ff[i-1];
         assign prev_meta = meta_ff[i-1];
      end

      assign trial = prev_res + STEP_BIT;
      assign take  = RW'(prev_rad) >= trial;

      always_ff @(posedge clock) begin
         rad_ff[i]  <= take ? QW'(RW'(prev_rad) - trial) : prev_rad;
         res_ff[i]  <= take ? (prev_res >> 1) + STEP_BIT : prev_res >> 1;
         frac_ff[i] <= prev_frac;
         meta_ff[i] <= prev_meta;
      end
   end

   assign out_valid = vld_ff[SQ_STEPS-1];
   assign out_meta  = meta_ff[SQ_STEPS-1];
   assign out_root  = res_ff[SQ_STEPS-1][GAIN_W-1:0];
   assign out_frac  = frac_ff[SQ_STEPS-1];

endmodule

// File: sv/spectral_noise_gain_rule_top.sv
// Spectral noise gain rule: one bin beat in, one Q1.15 gain beat out, fully pipelined.
// Depends on snrg_pkg, snrg_front, snrg_div and snrg_sqrt.
// The gain beat is strobed on rsp_valid after passing the front end, divider, square root and output register.
// Throughput: one bin per cycle; busy is always low and the result strobe cannot stall.
// The 30-stage divider and 16-stage square root set the depth, not the rate.
// Reset (synchronous, active high) clears every valid bit; bins in flight are dropped.
module spectral_noise_gain_rule_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_signal_power,
   input  logic [31:0] req_noise_power,
   input  logic [15:0] req_oversub_factor,
   input  logic [15:0] req_floor_factor,
   input  logic        req_last_bin,
   output logic        rsp_valid,
   output logic [15:0] rsp_gain,
   output logic        rsp_frame_end
);
   import snrg_pkg::*;

   // Every bin is independent, so the pipeline never needs to hold a beat off.
   logic              accept;
   rule_type          rule;

   logic              fr_valid;
   meta_type          fr_meta;
   logic [DW-1:0]     fr_num, fr_den;

   logic              dv_valid;
   meta_type          dv_meta;
   logic [QW-1:0]     dv_quot;

   logic              sq_valid;
   meta_type          sq_meta;
   logic [GAIN_W-1:0] sq_root;
   logic [FRAC_W-1:0] sq_frac;

   logic              rsp_valid_ff;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              frame_end_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign rule   = rule_type'(req_type);

   // The front end squares the powers, forms the scaled noise products, and decides the
   // rule. Items that need no division leave it with a fixed gain and ride the pipeline.
   snrg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_rule   (rule),
      .in_s      (PW'(req_signal_power)),
      .in_n      (PW'(req_noise_power)),
      .in_alpha  (req_oversub_factor),
      .in_beta   (req_floor_factor),
      .in_last   (req_last_bin),
      .out_valid (fr_valid),
      .out_meta  (fr_meta),
      .out_num   (fr_num),
      .out_den   (fr_den)
   );

   // Wiener and generalized rules share this divider. Wiener uses the top bits of the
   // 30-bit fraction, which equals floor(2^15 * (S-N) / S).
   snrg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_meta   (fr_meta),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .out_valid (dv_valid),
      .out_meta  (dv_meta),
      .out_quot  (dv_quot)
   );

   snrg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_meta   (dv_meta),
      .in_quot   (dv_quot),
      .out_valid (sq_valid),
      .out_meta  (sq_meta),
      .out_root  (sq_root),
      .out_frac  (sq_frac)
   );

   // Final selection: a fixed gain, the square root, or the Wiener fraction.
   always_comb begin
      if (sq_meta.is_fixed) begin
         gain_in = sq_meta.fixed_gain;
      end else if (sq_meta.use_sqrt) begin
         gain_in = sq_root;
      end else begin
         gain_in = GAIN_W'(sq_frac);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      gain_ff      <= gain_in;
      frame_end_ff <= sq_meta.frame_end;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gain      = gain_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// File: sv/snrg_checker.sv
// Port-level checker for the spectral noise gain rule top, with its bind statement.
// Depends on snrg_pkg and spectral_noise_gain_rule_top.
module snrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic [15:0] rsp_gain
);
   import snrg_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised although the pipeline never stalls");

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat produced no result at the expected latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result strobe without a matching accepted beat");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain <= GAIN_ONE)
      else $error("gain above unity");

   a_gating_binary: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == RULE_GATING) |->
         ##LATENCY (rsp_gain == GAIN_ONE || rsp_gain == GAIN_ZERO))
      else $error("gating rule gave a gain other than zero or one");

endmodule

bind spectral_noise_gain_rule_top snrg_checker u_snrg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_type  (req_type),
   .rsp_valid (rsp_valid),
   .rsp_gain  (rsp_gain)
);
